// ===== hw/rtl/est_pkg.sv =====
// Package for the edge string tokenizer: widths, character codes, enums,
// the queue entry type and the power-of-ten tables.
// Depends on nothing; every other file of the block uses it.
package est_pkg;

   localparam int MAX_DEC_FRAC_DIGITS = 6;
   localparam int OUT_FRAC_BITS       = 16;

   localparam int CHAR_W          = 8;
   localparam int INT_W           = 40;
   localparam int VALUE_W         = 40;
   localparam int CNT_W           = 3;
   localparam int HEX_INT_W       = 24;
   localparam int HEX_FRAC_BITS   = 8;
   localparam int HEX_FRAC_DIGITS = 2;
   localparam int TWIPS_PER_PIXEL = 20;

   // Power of ten for a small digit count.
   function automatic longint pow10(input int n);
      longint acc;
      acc = 1;
      for (int i = 0; i < n; i++) begin
         acc = acc * 10;
      end
      return acc;
   endfunction

   localparam longint POW10_MAX   = pow10(MAX_DEC_FRAC_DIGITS);
   localparam int     P_W         = $clog2(POW10_MAX + 1);
   localparam int     F_W         = (P_W > HEX_FRAC_BITS) ? P_W : HEX_FRAC_BITS;
   localparam longint HEX_DEN     = TWIPS_PER_PIXEL * (longint'(1) << HEX_FRAC_BITS);
   localparam longint DEC_DEN_MAX = TWIPS_PER_PIXEL * POW10_MAX;
   localparam longint DEN_MAX     = (DEC_DEN_MAX > HEX_DEN) ? DEC_DEN_MAX : HEX_DEN;
   localparam int     DEN_W       = $clog2(DEN_MAX + 1);
   localparam int     X_W         = INT_W + P_W;
   localparam int     DVD_W       = X_W + OUT_FRAC_BITS + 1;
   localparam int     DCNT_W      = $clog2(DVD_W + 1);

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;
   localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
   localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UC_F   = 8'h46;
   localparam logic [CHAR_W-1:0] CH_UC_S   = 8'h53;
   localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
   localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LC_F   = 8'h66;
   localparam logic [CHAR_W-1:0] CH_BAR    = 8'h7C;

   typedef enum logic [1:0] {
      KIND_COMMAND = 2'd0,
      KIND_VALUE   = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_INT   = 2'd1,
      PH_FRAC  = 2'd2,
      PH_REST  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_PREP,
      BK_DIV,
      BK_OUT
   } back_state_type;

   // One pending result: a command, an end mark, or a finished token to scale.
   typedef struct packed {
      kind_type            kind;
      logic [CHAR_W-1:0]   cmd;
      logic                last;
      logic                is_hex;
      logic                neg;
      logic [INT_W-1:0]    int_acc;
      logic [F_W-1:0]      frac;
      logic [CNT_W-1:0]    cnt;
   } entry_type;

   function automatic logic [P_W-1:0] pow10_of(input logic [CNT_W-1:0] cnt);
      return P_W'(pow10(int'(cnt)));
   endfunction

   function automatic logic [DEN_W-1:0] dec_den_of(input logic [CNT_W-1:0] cnt);
      return DEN_W'(TWIPS_PER_PIXEL * pow10(int'(cnt)));
   endfunction

endpackage

// ===== hw/rtl/est_if.sv =====
// Handshake interfaces of the edge string tokenizer: the byte channel and
// the result channel. Depends on est_pkg.
interface est_req_if;
   logic                          valid;
   logic                          ready;
   logic [est_pkg::CHAR_W-1:0]    char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface est_rsp_if;
   logic                          valid;
   logic                          ready;
   est_pkg::kind_type             kind;
   logic [est_pkg::CHAR_W-1:0]    command_char;
   logic signed [est_pkg::VALUE_W-1:0] value;
   logic                          last_of_run;

   modport source (output valid, output kind, output command_char, output value,
                   output last_of_run, input ready);
   modport sink   (input valid, input kind, input command_char, input value,
                   input last_of_run, output ready);
endinterface

// ===== hw/rtl/edge_string_tokenizer.sv =====
// Top level of the edge string tokenizer: front end, result queue and
// back end. Depends on est_pkg, est_if, est_front, est_fifo and est_back.

// The block takes a vector edge string one byte per word on req_ch and
// returns tokens on rsp_ch. Whitespace separates tokens, each of the bytes
// ! | / [ ] S comes out as a command word, any other run of bytes comes out
// as one value word when it ends, and byte 0 gives an end word and clears
// all token state. Values are pixels (twips over twenty) in signed fixed
// point with sixteen fraction bits, rounded to nearest and saturated to 40
// bits; a token that starts with # is read as 24.8 hex fixed point. The
// front end takes one byte per cycle while the queue has room, except
// that a byte which closes a value and is itself a command or the end
// queues two words and holds off the next byte until the second is
// queued. The back end moves a command or end word straight to the output
// register. A value word passes in the back end through a multiply step,
// a setup step, 77 steps of the bit-serial divider that scales the token
// and an output step; a two-entry queue between the ends lets the front
// keep taking bytes of the next token while a value is being scaled. The
// output register holds a finished word until the receiver takes it,
// and the back end starts the next queued word once that register is free.
module edge_string_tokenizer (
   input  logic       clock,
   input  logic       reset,
   est_req_if.sink    req_ch,
   est_rsp_if.source  rsp_ch
);

   logic                 push, pop, full, empty;
   est_pkg::entry_type   push_data, pop_data;

   // Classifies bytes and gathers token digits.
   est_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .fifo_full (full),
      .push      (push),
      .push_data (push_data)
   );

   // Pending words between the two halves.
   est_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   // Scales values and presents results.
   est_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp       (rsp_ch)
   );

endmodule

// ===== hw/rtl/est_front.sv =====
// Front end of the tokenizer: takes bytes, classifies them, gathers token
// state and queues results. Depends on est_pkg and est_if.
module est_front (
   input  logic                clock,
   input  logic                reset,
   est_req_if.sink             req,
   input  logic                fifo_full,
   output logic                push,
   output est_pkg::entry_type  push_data
);

   logic                          active_ff, active_in;
   logic                          hex_ff, hex_in;
   est_pkg::phase_type            phase_ff, phase_in;
   logic                          neg_ff, neg_in;
   logic [est_pkg::INT_W-1:0]     int_ff, int_in;
   logic [est_pkg::F_W-1:0]       frac_ff, frac_in;
   logic [est_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic                          seen_ff, seen_in;
   logic                          pend_ff, pend_in;
   est_pkg::entry_type            pend_data_ff, pend_data_in;

   logic [est_pkg::CHAR_W-1:0]    c;
   logic                          accept;
   logic                          is_space, is_cmd, is_end, ends;
   logic                          is_sign, is_dot, dec_digit, hex_digit;
   logic [3:0]                    hv;
   logic [est_pkg::INT_W+3:0]     int10;
   logic [est_pkg::F_W+3:0]       frac10;
   logic                          early;

   // Feed results for the current byte.
   est_pkg::phase_type            f_phase;
   logic                          f_neg, f_seen;
   logic [est_pkg::INT_W-1:0]     f_int;
   logic [est_pkg::F_W-1:0]       f_frac;
   logic [est_pkg::CNT_W-1:0]     f_cnt;

   est_pkg::entry_type            val_entry, tail_entry;

   assign c         = req.char_code;
   assign req.ready = !pend_ff && !fifo_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      is_space  = (c == est_pkg::CH_TAB) || (c == est_pkg::CH_LF) ||
                  (c == est_pkg::CH_CR) || (c == est_pkg::CH_SPACE);
      is_cmd    = (c == est_pkg::CH_BANG) || (c == est_pkg::CH_BAR) ||
                  (c == est_pkg::CH_SLASH) || (c == est_pkg::CH_LBRACK) ||
                  (c == est_pkg::CH_RBRACK) || (c == est_pkg::CH_UC_S);
      is_end    = (c == est_pkg::CH_NUL);
      ends      = is_space || is_cmd || is_end;
      is_sign   = (c == est_pkg::CH_PLUS) || (c == est_pkg::CH_MINUS);
      is_dot    = (c == est_pkg::CH_DOT);
      dec_digit = (c >= est_pkg::CH_0) && (c <= est_pkg::CH_9);
      hex_digit = dec_digit;
      hv        = c[3:0];
      if (((c >= est_pkg::CH_LC_A) && (c <= est_pkg::CH_LC_F)) ||
          ((c >= est_pkg::CH_UC_A) && (c <= est_pkg::CH_UC_F))) begin
         hex_digit = 1'b1;
         hv        = c[3:0] + 4'd9;
      end
      early = (phase_ff == est_pkg::PH_START) || (phase_ff == est_pkg::PH_INT);

      // Times ten by shift and add, plus the digit.
      int10  = {1'b0, int_ff, 3'b000} + {3'b000, int_ff, 1'b0} +
               {{est_pkg::INT_W{1'b0}}, c[3:0]};
      frac10 = {1'b0, frac_ff, 3'b000} + {3'b000, frac_ff, 1'b0} +
               {{est_pkg::F_W{1'b0}}, c[3:0]};

      f_phase = phase_ff;
      f_neg   = neg_ff;
      f_seen  = seen_ff;
      f_int   = int_ff;
      f_frac  = frac_ff;
      f_cnt   = cnt_ff;

      if (hex_ff) begin
         priority if ((phase_ff == est_pkg::PH_START) && is_sign) begin
            f_neg   = (c == est_pkg::CH_MINUS);
            f_phase = est_pkg::PH_INT;
         end else if (early && hex_digit) begin
            // Only the low 24 bits of the integer are kept.
            f_int   = est_pkg::INT_W'({int_ff[est_pkg::HEX_INT_W-5:0], hv});
            f_seen  = 1'b1;
            f_phase = est_pkg::PH_INT;
         end else if (early && is_dot &&
                      ((phase_ff == est_pkg::PH_START) || seen_ff)) begin
            f_phase = est_pkg::PH_FRAC;
         end else if ((phase_ff == est_pkg::PH_FRAC) && hex_digit) begin
            if (cnt_ff < est_pkg::CNT_W'(est_pkg::HEX_FRAC_DIGITS)) begin
               f_frac = est_pkg::F_W'({frac_ff[3:0], hv});
               f_cnt  = cnt_ff + 1'b1;
            end
         end else begin
            f_phase = est_pkg::PH_REST;
         end
      end else begin
         priority if ((phase_ff == est_pkg::PH_START) && is_sign) begin
            f_neg   = (c == est_pkg::CH_MINUS);
            f_phase = est_pkg::PH_INT;
         end else if (early && dec_digit) begin
            // A huge integer part sticks at all ones.
            f_int   = (int10[est_pkg::INT_W+3:est_pkg::INT_W] != 4'd0) ?
                      {est_pkg::INT_W{1'b1}} : int10[est_pkg::INT_W-1:0];
            f_phase = est_pkg::PH_INT;
         end else if (early && is_dot) begin
            f_phase = est_pkg::PH_FRAC;
         end else if ((phase_ff == est_pkg::PH_FRAC) && dec_digit) begin
            if (cnt_ff < est_pkg::CNT_W'(est_pkg::MAX_DEC_FRAC_DIGITS)) begin
               f_frac = frac10[est_pkg::F_W-1:0];
               f_cnt  = cnt_ff + 1'b1;
            end
         end else begin
            f_phase = est_pkg::PH_REST;
         end
      end
   end

   always_comb begin
      val_entry         = '0;
      val_entry.kind    = est_pkg::KIND_VALUE;
      val_entry.last    = !(is_end || is_cmd);
      val_entry.is_hex  = hex_ff;
      val_entry.neg     = neg_ff;
      val_entry.int_acc = int_ff;
      val_entry.frac    = frac_ff;
      val_entry.cnt     = cnt_ff;

      tail_entry      = '0;
      tail_entry.kind = is_end ? est_pkg::KIND_END : est_pkg::KIND_COMMAND;
      tail_entry.cmd  = is_end ? '0 : c;
      tail_entry.last = 1'b1;
   end

   always_comb begin
      active_in    = active_ff;
      hex_in       = hex_ff;
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      int_in       = int_ff;
      frac_in      = frac_ff;
      cnt_in       = cnt_ff;
      seen_in      = seen_ff;
      pend_in      = pend_ff;
      pend_data_in = pend_data_ff;
      push         = 1'b0;
      push_data    = val_entry;

      if (pend_ff) begin
         // Second result of the last byte waits for room in the queue.
         push      = !fifo_full;
         push_data = pend_data_ff;
         if (!fifo_full) begin
            pend_in = 1'b0;
         end
      end else if (accept) begin
         if (active_ff && !ends) begin
            phase_in = f_phase;
            neg_in   = f_neg;
            seen_in  = f_seen;
            int_in   = f_int;
            frac_in  = f_frac;
            cnt_in   = f_cnt;
         end else if (active_ff) begin
            push         = 1'b1;
            push_data    = val_entry;
            pend_in      = is_end || is_cmd;
            pend_data_in = tail_entry;
            active_in    = 1'b0;
            hex_in       = 1'b0;
            phase_in     = est_pkg::PH_START;
            neg_in       = 1'b0;
            int_in       = '0;
            frac_in      = '0;
            cnt_in       = '0;
            seen_in      = 1'b0;
         end else if (is_end || is_cmd) begin
            push      = 1'b1;
            push_data = tail_entry;
         end else if (!is_space) begin
            // Token state is clear here, so the feed starts from reset values.
            active_in = 1'b1;
            hex_in    = (c == est_pkg::CH_HASH);
            if (c != est_pkg::CH_HASH) begin
               phase_in = f_phase;
               neg_in   = f_neg;
               int_in   = f_int;
               frac_in  = f_frac;
               cnt_in   = f_cnt;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         hex_ff    <= 1'b0;
         phase_ff  <= est_pkg::PH_START;
         neg_ff    <= 1'b0;
         int_ff    <= '0;
         frac_ff   <= '0;
         cnt_ff    <= '0;
         seen_ff   <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         hex_ff    <= hex_in;
         phase_ff  <= phase_in;
         neg_ff    <= neg_in;
         int_ff    <= int_in;
         frac_ff   <= frac_in;
         cnt_ff    <= cnt_in;
         seen_ff   <= seen_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_data_ff <= pend_data_in;
   end

endmodule

// ===== hw/rtl/est_fifo.sv =====
// Short queue of pending results between the front and back ends.
// Depends on est_pkg.
module est_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  est_pkg::entry_type  push_data,
   output logic                full,
   input  logic                pop,
   output est_pkg::entry_type  pop_data,
   output logic                empty
);

   est_pkg::entry_type                mem [est_pkg::FIFO_DEPTH];
   logic [est_pkg::FIFO_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [est_pkg::FIFO_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [est_pkg::FIFO_CNT_W-1:0]    count_ff, count_in;

   assign full     = (count_ff == est_pkg::FIFO_CNT_W'(est_pkg::FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == est_pkg::FIFO_PTR_W'(est_pkg::FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == est_pkg::FIFO_PTR_W'(est_pkg::FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= est_pkg::FIFO_CNT_W'(est_pkg::FIFO_DEPTH))
      else $error("queue count out of range");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a write");

endmodule

// ===== hw/rtl/est_back.sv =====
// Back end of the tokenizer: takes queued results, scales token values to
// pixels with a shared bit-serial divider, and drives the result register.
// Depends on est_pkg and est_if.
module est_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  est_pkg::entry_type  pop_data,
   output logic                pop,
   est_rsp_if.source           rsp
);

   est_pkg::back_state_type          state_ff, state_in;
   est_pkg::entry_type               tok_ff, tok_in;
   logic                             sign_ff, sign_in;
   logic [est_pkg::X_W-1:0]          x_ff, x_in;
   logic [est_pkg::DEN_W-1:0]        den_ff, den_in;
   logic [est_pkg::DVD_W-1:0]        dvd_ff, dvd_in;
   logic [est_pkg::DEN_W-1:0]        rem_ff, rem_in;
   logic [est_pkg::VALUE_W-1:0]      quot_ff, quot_in;
   logic                             ovf_ff, ovf_in;
   logic [est_pkg::DCNT_W-1:0]       dcnt_ff, dcnt_in;

   logic                             out_valid_ff, out_valid_in;
   est_pkg::kind_type                out_kind_ff, out_kind_in;
   logic [est_pkg::CHAR_W-1:0]       out_cmd_ff, out_cmd_in;
   logic [est_pkg::VALUE_W-1:0]      out_value_ff, out_value_in;
   logic                             out_last_ff, out_last_in;

   logic                             out_free;
   logic [est_pkg::HEX_INT_W-1:0]    hex_ip;
   logic [est_pkg::HEX_FRAC_BITS-1:0] hex_fb;
   logic [est_pkg::HEX_INT_W+est_pkg::HEX_FRAC_BITS-1:0] hex_raw;
   logic [est_pkg::HEX_INT_W+est_pkg::HEX_FRAC_BITS:0]   hex_mag;
   logic [est_pkg::X_W-1:0]          dec_x;
   logic [est_pkg::DEN_W:0]          trial, diff;
   logic                             qbit;
   logic                             over;
   logic [est_pkg::VALUE_W-1:0]      mag40, signed_val;

   assign rsp.valid        = out_valid_ff;
   assign rsp.kind         = out_kind_ff;
   assign rsp.command_char = out_cmd_ff;
   assign rsp.value        = out_value_ff;
   assign rsp.last_of_run  = out_last_ff;
   assign out_free         = !out_valid_ff || rsp.ready;

   // Token to magnitude: hex is 24.8 two's complement, decimal is I*10^n+F.
   always_comb begin
      hex_ip  = tok_ff.neg ? (est_pkg::HEX_INT_W'(0) - tok_ff.int_acc[est_pkg::HEX_INT_W-1:0])
                           : tok_ff.int_acc[est_pkg::HEX_INT_W-1:0];
      unique case (tok_ff.cnt)
         est_pkg::CNT_W'(0): hex_fb = '0;
         est_pkg::CNT_W'(1): hex_fb = {tok_ff.frac[3:0], 4'b0000};
         default:            hex_fb = tok_ff.frac[est_pkg::HEX_FRAC_BITS-1:0];
      endcase
      hex_raw = {hex_ip, hex_fb};
      hex_mag = hex_raw[$high(hex_raw)] ?
                ({1'b1, {($bits(hex_raw)){1'b0}}} - {1'b0, hex_raw}) :
                {1'b0, hex_raw};
      dec_x   = est_pkg::X_W'(tok_ff.int_acc) * est_pkg::X_W'(est_pkg::pow10_of(tok_ff.cnt)) +
                est_pkg::X_W'(tok_ff.frac);
   end

   // One restoring division step per cycle.
   always_comb begin
      trial = {rem_ff, dvd_ff[est_pkg::DVD_W-1]};
      diff  = trial - {1'b0, den_ff};
      qbit  = (trial >= {1'b0, den_ff});
   end

   // Sign and saturation of the quotient.
   always_comb begin
      if (sign_ff) begin
         over       = ovf_ff || (quot_ff[est_pkg::VALUE_W-1] &&
                                 (quot_ff[est_pkg::VALUE_W-2:0] != '0));
         mag40      = over ? {1'b1, {(est_pkg::VALUE_W-1){1'b0}}} : quot_ff;
         signed_val = est_pkg::VALUE_W'(0) - mag40;
      end else begin
         over       = ovf_ff || quot_ff[est_pkg::VALUE_W-1];
         mag40      = quot_ff;
         signed_val = over ? {1'b0, {(est_pkg::VALUE_W-1){1'b1}}} : quot_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      tok_in       = tok_ff;
      sign_in      = sign_ff;
      x_in         = x_ff;
      den_in       = den_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      ovf_in       = ovf_ff;
      dcnt_in      = dcnt_ff;
      pop          = 1'b0;
      out_valid_in = rsp.ready ? 1'b0 : out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_cmd_in   = out_cmd_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         est_pkg::BK_IDLE: begin
            if (!empty && out_free) begin
               pop = 1'b1;
               if (pop_data.kind == est_pkg::KIND_VALUE) begin
                  tok_in   = pop_data;
                  state_in = est_pkg::BK_MUL;
               end else begin
                  out_valid_in = 1'b1;
                  out_kind_in  = pop_data.kind;
                  out_cmd_in   = pop_data.cmd;
                  out_value_in = '0;
                  out_last_in  = pop_data.last;
               end
            end
         end
         est_pkg::BK_MUL: begin
            if (tok_ff.is_hex) begin
               x_in    = est_pkg::X_W'(hex_mag);
               sign_in = hex_raw[$high(hex_raw)];
               den_in  = est_pkg::DEN_W'(est_pkg::HEX_DEN);
            end else begin
               x_in    = dec_x;
               sign_in = tok_ff.neg;
               den_in  = est_pkg::dec_den_of(tok_ff.cnt);
            end
            state_in = est_pkg::BK_PREP;
         end
         est_pkg::BK_PREP: begin
            // Rounding to nearest: add half the divisor before dividing.
            dvd_in   = (est_pkg::DVD_W'(x_ff) << est_pkg::OUT_FRAC_BITS) +
                       est_pkg::DVD_W'(den_ff >> 1);
            rem_in   = '0;
            quot_in  = '0;
            ovf_in   = 1'b0;
            dcnt_in  = est_pkg::DCNT_W'(est_pkg::DVD_W);
            state_in = est_pkg::BK_DIV;
         end
         est_pkg::BK_DIV: begin
            rem_in  = qbit ? diff[est_pkg::DEN_W-1:0] : trial[est_pkg::DEN_W-1:0];
            dvd_in  = dvd_ff << 1;
            quot_in = {quot_ff[est_pkg::VALUE_W-2:0], qbit};
            ovf_in  = ovf_ff || quot_ff[est_pkg::VALUE_W-1];
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == est_pkg::DCNT_W'(1)) begin
               state_in = est_pkg::BK_OUT;
            end
         end
         est_pkg::BK_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = est_pkg::KIND_VALUE;
               out_cmd_in   = '0;
               out_value_in = signed_val;
               out_last_in  = tok_ff.last;
               state_in     = est_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = est_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= est_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff       <= tok_in;
      sign_ff      <= sign_in;
      x_ff         <= x_in;
      den_ff       <= den_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      ovf_ff       <= ovf_in;
      dcnt_ff      <= dcnt_in;
      out_kind_ff  <= out_kind_in;
      out_cmd_ff   <= out_cmd_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

endmodule

// ===== test/est_token_checker.sv =====
// Checker for the edge string tokenizer: watches the byte and result channels,
// predicts the result words of every accepted byte and compares them in order.
// Depends on est_pkg and the channel interfaces in est_if.
module est_token_checker
   import est_pkg::*;
(
   input  logic clock,
   input  logic reset,
   est_req_if   req_ch,
   est_rsp_if   rsp_ch,
   output int   errors,
   output int   pending,
   output int   value_words,
   output int   command_words,
   output int   end_words
);

   localparam int REPORT_LIMIT = 30;
   localparam int FRAC_ACC_W   = 24;

   typedef struct {
      kind_type            kind;
      logic [CHAR_W-1:0]   cmd;
      logic [VALUE_W-1:0]  value;
      logic                last;
   } token_word_t;

   token_word_t expected_words[$];

   // Token state of the predictor.
   logic                  in_token;
   logic                  token_hex;
   logic                  hex_seen;
   logic                  minus;
   phase_type             phase;
   logic [INT_W-1:0]      int_acc;
   logic [FRAC_ACC_W-1:0] frac_acc;
   logic [CNT_W-1:0]      frac_cnt;

   function automatic logic is_white(input logic [CHAR_W-1:0] c);
      return c == CH_LF || c == CH_CR || c == CH_SPACE || c == CH_TAB;
   endfunction

   function automatic logic is_cmd_byte(input logic [CHAR_W-1:0] c);
      return c == CH_BANG || c == CH_BAR || c == CH_SLASH || c == CH_LBRACK ||
             c == CH_RBRACK || c == CH_UC_S;
   endfunction

   function automatic int hex_digit(input logic [CHAR_W-1:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
      if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
      return -1;
   endfunction

   task automatic clear_token();
      in_token  = 1'b0;
      token_hex = 1'b0;
      hex_seen  = 1'b0;
      minus     = 1'b0;
      phase     = PH_START;
      int_acc   = '0;
      frac_acc  = '0;
      frac_cnt  = '0;
   endtask

   task automatic feed_hex(input logic [CHAR_W-1:0] c);
      int d;
      d = hex_digit(c);
      if (phase == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
         minus = (c == CH_MINUS);
         phase = PH_INT;
      end else if (phase <= PH_INT && d >= 0) begin
         // Only the low 24 bits of the integer survive.
         int_acc  = INT_W'({int_acc[HEX_INT_W-5:0], 4'(d)});
         hex_seen = 1'b1;
         phase    = PH_INT;
      end else if (phase <= PH_INT && c == CH_DOT && (phase == PH_START || hex_seen)) begin
         phase = PH_FRAC;
      end else if (phase == PH_FRAC && d >= 0) begin
         if (frac_cnt < HEX_FRAC_DIGITS) begin
            frac_acc = {frac_acc[FRAC_ACC_W-5:0], 4'(d)};
            frac_cnt = frac_cnt + 1'b1;
         end
      end else begin
         phase = PH_REST;
      end
   endtask

   task automatic feed_decimal(input logic [CHAR_W-1:0] c);
      logic        digit;
      logic [63:0] d;
      logic [63:0] acc_full;
      digit    = (c >= CH_0 && c <= CH_9);
      d        = digit ? 64'(c - CH_0) : 64'd0;
      acc_full = (64'd1 << INT_W) - 1;
      if (phase == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
         minus = (c == CH_MINUS);
         phase = PH_INT;
      end else if (phase <= PH_INT && digit) begin
         if (64'(int_acc) > (acc_full - d) / 10) int_acc = '1;
         else int_acc = INT_W'(64'(int_acc) * 10 + d);
         phase = PH_INT;
      end else if (phase <= PH_INT && c == CH_DOT) begin
         phase = PH_FRAC;
      end else if (phase == PH_FRAC && digit) begin
         if (frac_cnt < MAX_DEC_FRAC_DIGITS && frac_cnt < 7) begin
            frac_acc = FRAC_ACC_W'(64'(frac_acc) * 10 + d);
            frac_cnt = frac_cnt + 1'b1;
         end
      end else begin
         phase = PH_REST;
      end
   endtask

   function automatic logic [VALUE_W-1:0] clamp_signed(input logic [63:0] mag,
                                                      input logic neg);
      logic [63:0] pos_max;
      logic [63:0] neg_max;
      pos_max = (64'd1 << (VALUE_W - 1)) - 1;
      neg_max = 64'd1 << (VALUE_W - 1);
      if (neg) return VALUE_W'(64'd0 - ((mag > neg_max) ? neg_max : mag));
      return VALUE_W'((mag > pos_max) ? pos_max : mag);
   endfunction

   // A hex token is a 24.8 two's complement word; pixels are that over twenty.
   function automatic logic [VALUE_W-1:0] hex_pixels();
      logic [HEX_INT_W-1:0]     ip;
      logic [HEX_FRAC_BITS-1:0] fb;
      logic [31:0]              raw;
      logic [63:0]              mag;
      logic [63:0]              den;
      ip = minus ? -int_acc[HEX_INT_W-1:0] : int_acc[HEX_INT_W-1:0];
      case (frac_cnt)
         3'd0:    fb = '0;
         3'd1:    fb = {frac_acc[3:0], 4'h0};
         default: fb = frac_acc[HEX_FRAC_BITS-1:0];
      endcase
      raw = {ip, fb};
      mag = raw[31] ? (64'h1_0000_0000 - 64'(raw)) : 64'(raw);
      den = 64'(HEX_DEN);
      return clamp_signed(((mag << OUT_FRAC_BITS) + den / 2) / den, raw[31]);
   endfunction

   function automatic logic [VALUE_W-1:0] decimal_pixels();
      logic [63:0] p;
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] mag;
      p = 64'd1;
      for (int i = 0; i < int'(frac_cnt); i++) p = p * 10;
      q   = 64'(int_acc) / 64'(TWIPS_PER_PIXEL);
      r   = 64'(int_acc) % 64'(TWIPS_PER_PIXEL);
      den = 64'(TWIPS_PER_PIXEL) * p;
      num = (r * p + 64'(frac_acc)) << OUT_FRAC_BITS;
      mag = (q << OUT_FRAC_BITS) + (num + den / 2) / den;
      return clamp_signed(mag, minus);
   endfunction

   // Works out the words one byte causes: at most a value, then a command or end.
   task automatic tokenize_byte(input logic [CHAR_W-1:0] c);
      token_word_t made[2];
      int          n;
      logic        closes;
      n      = 0;
      closes = (c == CH_NUL) || is_white(c) || is_cmd_byte(c);
      if (in_token && !closes) begin
         if (token_hex) feed_hex(c);
         else feed_decimal(c);
      end else begin
         if (in_token) begin
            made[n] = '{KIND_VALUE, 8'd0, token_hex ? hex_pixels() : decimal_pixels(), 1'b0};
            n++;
            clear_token();
         end
         if (c == CH_NUL) begin
            made[n] = '{KIND_END, 8'd0, 40'd0, 1'b0};
            n++;
            clear_token();
         end else if (is_cmd_byte(c)) begin
            made[n] = '{KIND_COMMAND, c, 40'd0, 1'b0};
            n++;
         end else if (!is_white(c)) begin
            in_token  = 1'b1;
            token_hex = (c == CH_HASH);
            if (!token_hex) feed_decimal(c);
         end
         for (int i = 0; i < n; i++) begin
            made[i].last = (i == n - 1);
            expected_words.push_back(made[i]);
         end
      end
   endtask

   task automatic check_field(input string field, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      token_word_t w;
      if (reset) begin
         clear_token();
         expected_words.delete();
         errors        = 0;
         value_words   = 0;
         command_words = 0;
         end_words     = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            tokenize_byte(req_ch.char_code);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_words.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("%0t: unexpected word, expected none, actual kind %0d value %0d",
                           $time, rsp_ch.kind, rsp_ch.value);
               end
            end else begin
               w = expected_words.pop_front();
               check_field("kind", w.kind, rsp_ch.kind);
               check_field("command_char", w.cmd, rsp_ch.command_char);
               check_field("value", $signed(w.value), rsp_ch.value);
               check_field("last_of_run", w.last, rsp_ch.last_of_run);
               case (w.kind)
                  KIND_VALUE:   value_words++;
                  KIND_COMMAND: command_words++;
                  default:      end_words++;
               endcase
            end
         end
      end
      pending = expected_words.size();
   end

endmodule

// ===== test/tb_edge_string_tokenizer.sv =====
// Top of the edge string tokenizer testbench: clock, reset, byte stimulus,
// result-side flow control, watchdog and verdict.
// Depends on est_pkg, est_if, the tokenizer RTL and est_token_checker.
module tb_edge_string_tokenizer;
   import est_pkg::*;

   // Total bytes to send, the length of the one long output stall, the
   // settling time after the last word, and the no-progress limit.
   localparam int ITEM_TARGET    = 1800;
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_CYCLES   = 200;
   localparam int WATCHDOG_LIMIT = 3000;

   localparam logic [CHAR_W-1:0] COMMANDS [6] = '{CH_BANG, CH_BAR, CH_SLASH,
                                                  CH_LBRACK, CH_RBRACK, CH_UC_S};
   localparam logic [CHAR_W-1:0] WHITES [4]   = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};

   logic clock        = 1'b0;
   logic reset        = 1'b1;
   // Shared with the result-side process: random idling on or off, and a
   // one-shot request for the long stall.
   logic idle_on      = 1'b1;
   logic hold_request = 1'b0;
   int   bytes_sent   = 0;

   int errors;
   int pending;
   int value_words;
   int command_words;
   int end_words;

   est_req_if req_ch ();
   est_rsp_if rsp_ch ();

   edge_string_tokenizer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   est_token_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .errors        (errors),
      .pending       (pending),
      .value_words   (value_words),
      .command_words (command_words),
      .end_words     (end_words)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one byte, possibly after a short idle burst, and returns at the
   // edge where the block takes it. Valid stays high afterwards, so that
   // back-to-back words need no gap.
   task automatic send_byte(input logic [CHAR_W-1:0] c);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= c;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function automatic logic [CHAR_W-1:0] pick_command();
      return COMMANDS[$urandom_range(0, 5)];
   endfunction

   function automatic logic [CHAR_W-1:0] pick_white();
      return WHITES[$urandom_range(0, 3)];
   endfunction

   task automatic send_digit();
      send_byte(CH_0 + CHAR_W'($urandom_range(0, 9)));
   endtask

   // Hex digits come in both letter cases.
   task automatic send_hex_digit();
      int d;
      d = $urandom_range(0, 15);
      if (d < 10) send_byte(CH_0 + CHAR_W'(d));
      else if ($urandom_range(0, 1) == 1) send_byte(CH_UC_A + CHAR_W'(d - 10));
      else send_byte(CH_LC_A + CHAR_W'(d - 10));
   endtask

   // Tails that the parser does not take: exponents, a 0x prefix, inf and
   // nan, stray signs and dots, or any byte at all.
   task automatic send_junk();
      case ($urandom_range(0, 7))
         0: send_text("e5");
         1: send_text("0x1F");
         2: send_text("inf");
         3: send_text("nan");
         4: send_byte(CH_DOT);
         5: send_byte(CH_MINUS);
         6: send_byte(CH_HASH);
         default: send_byte(CHAR_W'($urandom_range(1, 255)));
      endcase
   endtask

   // A hex token: sign, integer digits (sometimes more than 24 bits' worth),
   // and a fraction with zero to four digits, of which only two count.
   task automatic send_hex_token();
      int n;
      send_byte(CH_HASH);
      case ($urandom_range(0, 3))
         0: send_byte(CH_MINUS);
         1: send_byte(CH_PLUS);
         default: ;
      endcase
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 6);
      repeat (n) send_hex_digit();
      if ($urandom_range(0, 3) != 0) begin
         send_byte(CH_DOT);
         repeat ($urandom_range(0, 4)) send_hex_digit();
      end
      if ($urandom_range(0, 7) == 0) send_junk();
   endtask

   // A decimal token: mostly short numbers, now and then one long enough to
   // saturate, and fractions both under and over the kept digit count.
   task automatic send_decimal_token();
      int n;
      case ($urandom_range(0, 3))
         0: send_byte(CH_MINUS);
         1: send_byte(CH_PLUS);
         default: ;
      endcase
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 5);
      repeat (n) send_digit();
      if ($urandom_range(0, 1) == 1) begin
         send_byte(CH_DOT);
         repeat ($urandom_range(0, 9)) send_digit();
      end
      if ($urandom_range(0, 7) == 0) send_junk();
   endtask

   // One edge string: a handful of tokens, each closed by whitespace, a
   // command or byte 0, usually ended by byte 0. Some strings are left open
   // so that the next one runs on into them.
   task automatic send_string();
      int n;
      n = $urandom_range(1, 8);
      repeat (n) begin
         case ($urandom_range(0, 9))
            0, 1, 2:    send_hex_token();
            3, 4, 5, 6: send_decimal_token();
            7:          send_byte(pick_command());
            8:          send_byte(CHAR_W'($urandom_range(0, 255)));
            default:    send_byte(pick_white());
         endcase
         case ($urandom_range(0, 5))
            0, 1:    send_byte(pick_command());
            2:       send_byte(CH_NUL);
            default: send_byte(pick_white());
         endcase
      end
      if ($urandom_range(0, 5) != 0) send_byte(CH_NUL);
   endtask

   initial begin : stimulus
      req_ch.valid     <= 1'b0;
      req_ch.char_code <= CH_NUL;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: a negative hex value whose single fraction digit
      // moves up a nibble, closed by a command so that one byte gives two
      // words; a fraction straight after the hash with a third digit to
      // drop; a decimal with more fraction digits than are kept; and a
      // token of byte 255 alone, which has no digits, closed by the end.
      send_text("#-1.8!");
      send_text("#.7fA ");
      send_text("-1.2345678/");
      send_byte(8'hFF);
      send_byte(CH_NUL);

      // Random strings, with idling switched on for most of them and off
      // for stretches.
      while (bytes_sent < 700) begin
         idle_on = ($urandom_range(0, 2) != 0);
         send_string();
      end

      // The result side stalls for a long time while bytes keep coming, so
      // that the queue and the front end fill and the byte channel stalls.
      idle_on      = 1'b1;
      hold_request = 1'b1;
      while (bytes_sent < 900) send_string();

      // Pause until every word owed so far has come out.
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);

      while (bytes_sent < 1500) begin
         idle_on = ($urandom_range(0, 2) != 0);
         send_string();
      end

      // Last part at full rate on both sides.
      idle_on = 1'b0;
      while (bytes_sent < ITEM_TARGET) send_string();
      send_byte(CH_NUL);
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes of hex, decimal and junk tokens; checked %0d words", bytes_sent,
               value_words + command_words + end_words);
      $display("(%0d values, %0d commands, %0d string ends), with stalls on both sides.",
               value_words, command_words, end_words);
      if (errors == 0) begin
         $display("tb_edge_string_tokenizer: clean");
      end else begin
         $display("tb_edge_string_tokenizer: errors");
      end
      $finish;
   end

   // Result side: ready is mostly high, drops for short random bursts while
   // idling is on, and drops once, for the long stall, on request.
   initial begin : receiver
      int gap;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   // Ends the run if no word moves on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_edge_string_tokenizer: errors");
      $finish;
   end

endmodule
